>>> hw/rtl/nsp_pkg.sv
package nsp_pkg;

   // field widths
   localparam int COORD_W = 32;
   localparam int WEIGHT_W = 16;
   localparam int RES_W = 7;
   localparam int INDEX_W = 8;
   localparam int STATUS_W = 2;

   // fixed-point formats
   localparam int QW = 20;        // parameter value, unsigned Q.16
   localparam int CW = 17;        // recursion coefficient, 0 .. 1.0
   localparam int BW = 18;        // basis value, Q2.16
   localparam int BIJ_W = 20;     // tensor basis
   localparam int TERM_W = 28;    // weighted term
   localparam int WSUM_W = 37;    // weight sum
   localparam int ACC_W = 64;     // coordinate accumulators
   localparam int PT_W = 3 * COORD_W + WEIGHT_W;

   localparam logic [CW-1:0] ONE_Q16 = 17'h10000;
   localparam int DIV3_S = 22;
   localparam logic [DIV3_S-1:0] DIV3_M = 22'd1398102;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_ZERO_WSUM = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_WRITE_ACK = 2'd3;

   // item kinds
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   // register indexes
   localparam logic REG_RES_U = 1'b0;
   localparam logic REG_RES_V = 1'b1;

   // clamped uniform knot vector
   function automatic int knot_at(int j, int n, int t);
      if (j < t) return 0;
      if (j <= n) return j - t + 1;
      return n - t + 2;
   endfunction

   // divide by a knot span of one to three
   function automatic logic [QW-1:0] div_small(logic [QW-1:0] x, logic [1:0] d);
      logic [QW+DIV3_S-1:0] prod;
      prod = (QW + DIV3_S)'(x) * (QW + DIV3_S)'(DIV3_M);
      case (d)
         2'd2: return x >> 1;
         2'd3: return QW'(prod >> DIV3_S);
         default: return x;
      endcase
   endfunction

endpackage

>>> hw/rtl/nsp_ram.sv
module nsp_ram #(
   parameter int WIDTH = 112,
   parameter int DEPTH = 36,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/nsp_div.sv
module nsp_div #(
   parameter int NW = 64,
   parameter int DW = 37
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic          done,
   output logic [NW-1:0] quot
);

   localparam int CNT_W = $clog2(NW + 1);

   logic [NW-1:0]    q_ff;
   logic [DW-1:0]    rem_ff;
   logic [DW-1:0]    den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DW:0]      trial;
   logic             ge;

   // one quotient bit a cycle, restoring
   always_comb begin
      trial = {rem_ff, q_ff[NW-1]};
      ge = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            q_ff <= num;
            rem_ff <= '0;
            den_ff <= den;
            cnt_ff <= CNT_W'(NW);
         end else if (busy_ff) begin
            q_ff <= {q_ff[NW-2:0], ge};
            rem_ff <= ge ? DW'(trial - {1'b0, den_ff}) : DW'(trial);
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = q_ff;

endmodule

>>> hw/rtl/nsp_basis.sv
module nsp_basis #(
   parameter int NCP = 6,
   parameter int ORD = 4,
   localparam int L = NCP + ORD - 1,
   localparam int IW = $clog2(L)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [nsp_pkg::QW-1:0] u,
   input  logic [IW-1:0]          rd_idx,
   output logic                   busy,
   output logic [nsp_pkg::BW-1:0] rd_data
);

   localparam int N = NCP - 1;
   localparam int NK = NCP + ORD;
   localparam int MW = $clog2(ORD + 1);

   logic [nsp_pkg::BW-1:0] b_ff [L];
   logic [nsp_pkg::BW-1:0] b_init [L];
   logic [nsp_pkg::QW-1:0] u_ff;
   logic [nsp_pkg::CW-1:0] c1_ff, c2_ff;
   logic [nsp_pkg::CW-1:0] c1, c2;
   logic [MW-1:0]          m_ff;
   logic [IW-1:0]          i_ff;
   logic                   ph_ff;
   logic                   busy_ff;
   logic [nsp_pkg::CW+nsp_pkg::BW-1:0] p1, p2;
   logic [nsp_pkg::BW-1:0] b_new;
   logic                   keep;

   // order-one values from the knot interval holding u
   always_comb begin
      int lo, hi;
      logic [nsp_pkg::QW-1:0] loq, hiq;
      for (int i = 0; i < L; i++) begin
         lo = nsp_pkg::knot_at(i, N, ORD);
         hi = nsp_pkg::knot_at(i + 1, N, ORD);
         loq = nsp_pkg::QW'(lo) << 16;
         hiq = nsp_pkg::QW'(hi) << 16;
         b_init[i] = ((loq < u && u <= hiq) || (i == 0 && loq <= u && u <= hiq))
                     ? nsp_pkg::BW'(nsp_pkg::ONE_Q16) : '0;
      end
   end

   // recursion coefficients for entry i_ff at level m_ff
   always_comb begin
      int ki, kim1, ki1, kim;
      logic [nsp_pkg::QW-1:0] kiq, kimq, q1, q2;
      ki = nsp_pkg::knot_at(int'(i_ff), N, ORD);
      kim1 = nsp_pkg::knot_at(int'(i_ff) + int'(m_ff) - 1, N, ORD);
      ki1 = nsp_pkg::knot_at(int'(i_ff) + 1, N, ORD);
      kim = nsp_pkg::knot_at(int'(i_ff) + int'(m_ff), N, ORD);
      kiq = nsp_pkg::QW'(ki) << 16;
      kimq = nsp_pkg::QW'(kim) << 16;
      q1 = nsp_pkg::div_small(u_ff - kiq, 2'(kim1 - ki));
      q2 = nsp_pkg::div_small(kimq - u_ff, 2'(kim - ki1));
      if (kim1 == ki) begin
         c1 = (u_ff == kiq) ? nsp_pkg::ONE_Q16 : '0;
      end else if (u_ff < kiq) begin
         c1 = '0;
      end else begin
         c1 = (q1 > nsp_pkg::QW'(nsp_pkg::ONE_Q16)) ? nsp_pkg::ONE_Q16 : nsp_pkg::CW'(q1);
      end
      if (kim == ki1) begin
         c2 = (u_ff == kimq) ? nsp_pkg::ONE_Q16 : '0;
      end else if (u_ff > kimq) begin
         c2 = '0;
      end else begin
         c2 = (q2 > nsp_pkg::QW'(nsp_pkg::ONE_Q16)) ? nsp_pkg::ONE_Q16 : nsp_pkg::CW'(q2);
      end
   end

   // entry i sits at the head of the rotating line
   always_comb begin
      p1 = c1_ff * b_ff[0];
      p2 = c2_ff * b_ff[1];
      b_new = nsp_pkg::BW'((p1 >> 16) + (p2 >> 16));
      keep = (int'(i_ff) + int'(m_ff)) >= NK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ph_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         ph_ff <= 1'b0;
         m_ff <= MW'(2);
         i_ff <= '0;
         u_ff <= u;
         for (int k = 0; k < L; k++) begin
            b_ff[k] <= b_init[k];
         end
      end else if (busy_ff) begin
         if (!ph_ff) begin
            c1_ff <= c1;
            c2_ff <= c2;
            ph_ff <= 1'b1;
         end else begin
            for (int k = 0; k < L - 1; k++) begin
               b_ff[k] <= b_ff[k + 1];
            end
            b_ff[L-1] <= keep ? b_ff[0] : b_new;
            ph_ff <= 1'b0;
            if (i_ff == IW'(L - 1)) begin
               i_ff <= '0;
               if (m_ff == MW'(ORD)) begin
                  busy_ff <= 1'b0;
               end else begin
                  m_ff <= m_ff + 1'b1;
               end
            end else begin
               i_ff <= i_ff + 1'b1;
            end
         end
      end
   end

   assign busy = busy_ff;
   assign rd_data = b_ff[rd_idx];

endmodule

>>> hw/rtl/nurbs_surface_point_evaluator.sv
// sequence: a write or an out-of-range evaluate goes to the done state, then loads the output register;
// an evaluate runs the u and v parameter divisions, the basis rows, the walk over the store and
// the three quotient divisions on the shared divider, then loads the output register;
// a zero weight sum skips the three quotient divisions
// throughput: one item at a time, next beat taken the cycle after the result is loaded,
// a result still held in the output register stalls the sequencer; reset: synchronous,
// active high, clears control state, resolutions return to 6, control store not cleared
module nurbs_surface_point_evaluator #(
   parameter int CTRL_U = 6,
   parameter int CTRL_V = 6,
   parameter int ORDER_U = 4,
   parameter int ORDER_V = 4
) (
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   // point_index, coord_x, coord_y, coord_z, point_weight, grid_row, grid_col, pad
   input  logic [135:0] req_tdata,
   // mode
   input  logic         req_tuser,
   // response stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // surf_x, surf_y, surf_z
   output logic [95:0]  rsp_tdata,
   // status
   output logic [1:0]   rsp_tuser,
   // register writes
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [6:0]   csr_wdata
);

   localparam int NPTS = CTRL_U * CTRL_V;
   localparam int AW = $clog2(NPTS);
   localparam int SPAN_U = CTRL_U - ORDER_U + 1;
   localparam int SPAN_V = CTRL_V - ORDER_V + 1;
   localparam int IU = $clog2(CTRL_U);
   localparam int JV = $clog2(CTRL_V);
   localparam int LU = CTRL_U + ORDER_U - 1;
   localparam int LV = CTRL_V + ORDER_V - 1;
   localparam int IWU = $clog2(LU);
   localparam int IWV = $clog2(LV);
   localparam int CW32 = nsp_pkg::COORD_W;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_DIVU  = 9'b000000010,
      ST_DIVV  = 9'b000000100,
      ST_BASIS = 9'b000001000,
      ST_WALK  = 9'b000010000,
      ST_DIVX  = 9'b000100000,
      ST_DIVY  = 9'b001000000,
      ST_DIVZ  = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type state_ff;

   // request fields
   logic [nsp_pkg::INDEX_W-1:0]  f_index;
   logic [CW32-1:0]              f_x, f_y, f_z;
   logic [nsp_pkg::WEIGHT_W-1:0] f_w;
   logic [nsp_pkg::RES_W-1:0]    f_row, f_col;

   assign f_index = req_tdata[7:0];
   assign f_x = req_tdata[39:8];
   assign f_y = req_tdata[71:40];
   assign f_z = req_tdata[103:72];
   assign f_w = req_tdata[119:104];
   assign f_row = req_tdata[126:120];
   assign f_col = req_tdata[133:127];

   // configuration
   logic [nsp_pkg::RES_W-1:0] res_u_ff, res_v_ff;
   logic [nsp_pkg::RES_W-1:0] ru, rv;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_u_ff <= 7'd6;
         res_v_ff <= 7'd6;
      end else if (csr_we) begin
         case (csr_addr)
            nsp_pkg::REG_RES_U: res_u_ff <= csr_wdata;
            nsp_pkg::REG_RES_V: res_v_ff <= csr_wdata;
            default: res_v_ff <= csr_wdata;
         endcase
      end
   end

   // zero acts as one, anything past 64 as 64
   always_comb begin
      ru = (res_u_ff == '0) ? 7'd1 : ((res_u_ff > 7'd64) ? 7'd64 : res_u_ff);
      rv = (res_v_ff == '0) ? 7'd1 : ((res_v_ff > 7'd64) ? 7'd64 : res_v_ff);
   end

   logic req_fire;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;

   // control store: x, y, z, weight from the low bits up
   logic                     ram_we, ram_re;
   logic [AW-1:0]            ram_waddr, ram_raddr;
   logic [nsp_pkg::PT_W-1:0] ram_wdata, ram_rdata;

   assign ram_we = req_fire && (req_tuser == nsp_pkg::MODE_WRITE)
                   && ({1'b0, f_index} < (nsp_pkg::INDEX_W + 1)'(NPTS));
   assign ram_waddr = AW'(f_index);
   assign ram_wdata = {f_w, f_z, f_y, f_x};

   nsp_ram #(.WIDTH(nsp_pkg::PT_W), .DEPTH(NPTS)) u_store (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re(ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // shared divider: u and v parameters, then the three quotients
   logic                        div_start, div_busy, div_done;
   logic [nsp_pkg::ACC_W-1:0]   div_num, div_quot;
   logic [nsp_pkg::WSUM_W-1:0]  div_den;

   nsp_div #(.NW(nsp_pkg::ACC_W), .DW(nsp_pkg::WSUM_W)) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(div_num),
      .den(div_den),
      .busy(div_busy),
      .done(div_done),
      .quot(div_quot)
   );

   // basis rows along u and v
   logic                   basis_start, bu_busy, bv_busy;
   logic [nsp_pkg::QW-1:0] u_ff;
   logic [nsp_pkg::BW-1:0] bu_rd, bv_rd;
   logic [IU-1:0]          ii_ff;
   logic [JV-1:0]          jj_ff;

   nsp_basis #(.NCP(CTRL_U), .ORD(ORDER_U)) u_basis_u (
      .clock(clock),
      .reset(reset),
      .start(basis_start),
      .u(u_ff),
      .rd_idx(IWU'(ii_ff)),
      .busy(bu_busy),
      .rd_data(bu_rd)
   );

   nsp_basis #(.NCP(CTRL_V), .ORD(ORDER_V)) u_basis_v (
      .clock(clock),
      .reset(reset),
      .start(basis_start),
      .u(nsp_pkg::QW'(div_quot)),
      .rd_idx(IWV'(jj_ff)),
      .busy(bv_busy),
      .rd_data(bv_rd)
   );

   // walk over the store: read, tensor basis, weighted term, products, sums
   logic [nsp_pkg::RES_W-1:0]    col_ff;
   logic [AW-1:0]                kk_ff;
   logic                         issue_ff, v1_ff, v2_ff, v3_ff;
   logic [nsp_pkg::BIJ_W-1:0]    bij_ff;
   logic [nsp_pkg::TERM_W-1:0]   term_ff;
   logic signed [CW32-1:0]       cx_ff, cy_ff, cz_ff;
   logic signed [CW32+nsp_pkg::TERM_W:0] px_ff, py_ff, pz_ff;
   logic [nsp_pkg::WSUM_W-1:0]   wsum_ff;
   logic signed [nsp_pkg::ACC_W-1:0] nx_ff, ny_ff, nz_ff;
   logic [2*nsp_pkg::BW-1:0]     bprod;
   logic [nsp_pkg::BIJ_W+nsp_pkg::WEIGHT_W-1:0] wprod;
   logic signed [nsp_pkg::TERM_W:0] term_s;
   logic                         walk_end;

   assign ram_re = issue_ff;
   assign ram_raddr = kk_ff;
   assign bprod = bu_rd * bv_rd;
   assign wprod = bij_ff * ram_rdata[nsp_pkg::PT_W-1 -: nsp_pkg::WEIGHT_W];
   assign term_s = {1'b0, term_ff};
   assign walk_end = (state_ff == ST_WALK) && !issue_ff && !v1_ff && !v2_ff && !v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= issue_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (state_ff == ST_BASIS && !bu_busy && !bv_busy) begin
            issue_ff <= 1'b1;
            kk_ff <= '0;
            ii_ff <= '0;
            jj_ff <= '0;
            wsum_ff <= '0;
            nx_ff <= '0;
            ny_ff <= '0;
            nz_ff <= '0;
         end else begin
            if (issue_ff) begin
               bij_ff <= bprod[2*nsp_pkg::BW-1:16];
               kk_ff <= kk_ff + 1'b1;
               if (jj_ff == JV'(CTRL_V - 1)) begin
                  jj_ff <= '0;
                  ii_ff <= ii_ff + 1'b1;
               end else begin
                  jj_ff <= jj_ff + 1'b1;
               end
               if (kk_ff == AW'(NPTS - 1)) begin
                  issue_ff <= 1'b0;
               end
            end
            if (v1_ff) begin
               term_ff <= wprod[nsp_pkg::BIJ_W+nsp_pkg::WEIGHT_W-1:8];
               cx_ff <= ram_rdata[CW32-1:0];
               cy_ff <= ram_rdata[2*CW32-1:CW32];
               cz_ff <= ram_rdata[3*CW32-1:2*CW32];
            end
            if (v2_ff) begin
               px_ff <= term_s * cx_ff;
               py_ff <= term_s * cy_ff;
               pz_ff <= term_s * cz_ff;
               wsum_ff <= wsum_ff + nsp_pkg::WSUM_W'(term_ff);
            end
            if (v3_ff) begin
               nx_ff <= nx_ff + nsp_pkg::ACC_W'(px_ff);
               ny_ff <= ny_ff + nsp_pkg::ACC_W'(py_ff);
               nz_ff <= nz_ff + nsp_pkg::ACC_W'(pz_ff);
            end
         end
      end
   end

   // magnitude of the sum headed for the divider
   function automatic logic [nsp_pkg::ACC_W-1:0] mag(logic signed [nsp_pkg::ACC_W-1:0] a);
      return a[nsp_pkg::ACC_W-1] ? nsp_pkg::ACC_W'(-a) : nsp_pkg::ACC_W'(a);
   endfunction

   // truncated quotient, sign applied, saturated to 32 bits
   function automatic logic [CW32-1:0] sat32(logic [nsp_pkg::ACC_W-1:0] q, logic neg);
      logic [CW32-1:0] lowq;
      lowq = q[CW32-1:0];
      if (neg) begin
         if (q > nsp_pkg::ACC_W'(64'h8000_0000)) return 32'h8000_0000;
         return CW32'(-lowq);
      end
      if (q > nsp_pkg::ACC_W'(64'h7FFF_FFFF)) return 32'h7FFF_FFFF;
      return lowq;
   endfunction

   // divider and basis launch
   always_comb begin
      div_start = 1'b0;
      div_num = '0;
      div_den = '0;
      basis_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            div_num = nsp_pkg::ACC_W'(f_row) * nsp_pkg::ACC_W'(SPAN_U) << 16;
            div_den = nsp_pkg::WSUM_W'(ru);
            div_start = req_fire && (req_tuser == nsp_pkg::MODE_EVAL)
                        && f_row <= ru && f_col <= rv;
         end
         ST_DIVU: begin
            div_num = nsp_pkg::ACC_W'(col_ff) * nsp_pkg::ACC_W'(SPAN_V) << 16;
            div_den = nsp_pkg::WSUM_W'(rv);
            div_start = div_done;
         end
         ST_DIVV: basis_start = div_done;
         ST_WALK: begin
            div_num = mag(nx_ff);
            div_den = wsum_ff;
            div_start = walk_end && (wsum_ff != '0);
         end
         ST_DIVX: begin
            div_num = mag(ny_ff);
            div_den = wsum_ff;
            div_start = div_done;
         end
         ST_DIVY: begin
            div_num = mag(nz_ff);
            div_den = wsum_ff;
            div_start = div_done;
         end
         default: div_start = 1'b0;
      endcase
   end

   // sequencer and result register
   logic [CW32-1:0]              ox_ff, oy_ff, oz_ff;
   logic [nsp_pkg::STATUS_W-1:0] ost_ff;
   logic                         rsp_valid_ff;
   logic [95:0]                  rsp_data_ff;
   logic [nsp_pkg::STATUS_W-1:0] rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a beat taken outside the done state empties the output register
         if (rsp_valid_ff && rsp_tready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  ox_ff <= '0;
                  oy_ff <= '0;
                  oz_ff <= '0;
                  col_ff <= f_col;
                  if (req_tuser == nsp_pkg::MODE_WRITE) begin
                     ost_ff <= ram_we ? nsp_pkg::STAT_WRITE_ACK : nsp_pkg::STAT_RANGE;
                     state_ff <= ST_DONE;
                  end else if (div_start) begin
                     state_ff <= ST_DIVU;
                  end else begin
                     ost_ff <= nsp_pkg::STAT_RANGE;
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_DIVU: begin
               if (div_done) begin
                  u_ff <= nsp_pkg::QW'(div_quot);
                  state_ff <= ST_DIVV;
               end
            end
            ST_DIVV: begin
               if (div_done) begin
                  state_ff <= ST_BASIS;
               end
            end
            ST_BASIS: begin
               if (!bu_busy && !bv_busy) begin
                  state_ff <= ST_WALK;
               end
            end
            ST_WALK: begin
               if (walk_end) begin
                  if (wsum_ff == '0) begin
                     ost_ff <= nsp_pkg::STAT_ZERO_WSUM;
                     state_ff <= ST_DONE;
                  end else begin
                     ost_ff <= nsp_pkg::STAT_OK;
                     state_ff <= ST_DIVX;
                  end
               end
            end
            ST_DIVX: begin
               if (div_done) begin
                  ox_ff <= sat32(div_quot, nx_ff[nsp_pkg::ACC_W-1]);
                  state_ff <= ST_DIVY;
               end
            end
            ST_DIVY: begin
               if (div_done) begin
                  oy_ff <= sat32(div_quot, ny_ff[nsp_pkg::ACC_W-1]);
                  state_ff <= ST_DIVZ;
               end
            end
            ST_DIVZ: begin
               if (div_done) begin
                  oz_ff <= sat32(div_quot, nz_ff[nsp_pkg::ACC_W-1]);
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               // wait for the output register to free up
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff <= {oz_ff, oy_ff, ox_ff};
                  rsp_user_ff <= ost_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

`ifndef ASSERT_OFF
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_store_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_IDLE && !issue_ff)
      else $error("store written during a walk");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");
`endif

endmodule
